FILE: rtl/core/lfps_pkg.sv
package lfps_pkg;

    typedef logic [2:0] op_t;

    localparam op_t OP_TICK   = 3'd0;
    localparam op_t OP_ON     = 3'd1;
    localparam op_t OP_OFF    = 3'd2;
    localparam op_t OP_TOGGLE = 3'd3;
    localparam op_t OP_FLASH  = 3'd4;
    localparam op_t OP_PULSE  = 3'd5;

    localparam int IDX_W    = 4;
    localparam int PERIOD_W = 24;
    localparam int COUNT_W  = 17;
    localparam int PULSES_W = 8;
    localparam int OUT_W    = 4;

    localparam int TICK_W   = 32;
    localparam int STORE_W  = 26;
    localparam int REP_W    = 18;
    localparam int BURST_W  = 9;
    localparam int NEED_W   = 25;
    localparam int CFG_W    = 16;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_POLARITY   = 2'd0;
    localparam cfg_idx_t CFG_MIN_PERIOD = 2'd1;
    localparam cfg_idx_t CFG_PULSE      = 2'd2;

    localparam logic [OUT_W-1:0]   POLARITY_RST   = 4'hF;
    localparam logic [CFG_W-1:0]   MIN_PERIOD_RST = 16'd100;
    localparam logic [CFG_W-1:0]   PULSE_RST      = 16'd200;
    localparam logic [STORE_W-1:0] PERIOD_RST     = 26'd500;
    localparam logic [BURST_W-1:0] BURST_IDLE     = 9'h1FF;

endpackage

FILE: rtl/core/lfps_if.sv
interface lfps_in_if import lfps_pkg::*; ();
    logic                        valid;
    logic                        ready;
    op_t                         op;
    logic [IDX_W-1:0]            led_index;
    logic [PERIOD_W-1:0]         period_ticks;
    logic signed [COUNT_W-1:0]   flash_count;
    logic [PULSES_W-1:0]         pulse_count;

    modport source (output valid, op, led_index, period_ticks, flash_count, pulse_count,
                    input ready);
    modport sink   (input valid, op, led_index, period_ticks, flash_count, pulse_count,
                    output ready);
endinterface

interface lfps_out_if import lfps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] pin_levels;
    logic [OUT_W-1:0] lit_flags;
    logic             ok;

    modport source (output valid, pin_levels, lit_flags, ok, input ready);
    modport sink   (input valid, pin_levels, lit_flags, ok, output ready);
endinterface

FILE: rtl/core/led_flash_pulse_sequencer_top.sv
// LED flash and pulse sequencer.
// in_ch carries one item per handshake: a millisecond tick or a command
// (on, off, toggle, flash, pulse) aimed at led_index. out_ch returns exactly
// one item per input item: pin levels after polarity, lit flags and ok.
// Configuration (polarity mask, minimum flash period, pulse length) is
// written through cfg_we/cfg_index/cfg_data; the user must write it only
// while no item is in flight, which the block itself does not enforce.
// Items go via the input register and per-LED logic to the result register.
// Throughput: one item per cycle unless out_ch stalls; every LED has its
// own update logic; the pulse product is formed before the input register.
// When out_ch stalls, the result register holds and the input register
// fills; in_ch.ready drops only once both are occupied.
// Reset: all LEDs dark and idle, tick counter zero, flash period 500,
// registers at polarity 0xF, minimum period 100, pulse length 200.
module led_flash_pulse_sequencer_top
    import lfps_pkg::*;
#(
    parameter int LED_COUNT = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  cfg_idx_t          cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    lfps_in_if.sink           in_ch,
    lfps_out_if.source        out_ch
);

    // configuration
    logic [OUT_W-1:0] pol_reg;
    logic [CFG_W-1:0] min_period_reg;
    logic [CFG_W-1:0] pulse_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg         <= POLARITY_RST;
            min_period_reg  <= MIN_PERIOD_RST;
            pulse_ticks_reg <= PULSE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLARITY:   pol_reg         <= cfg_data[OUT_W-1:0];
                CFG_MIN_PERIOD: min_period_reg  <= cfg_data;
                CFG_PULSE:      pulse_ticks_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // input register
    logic                      s1_valid_reg;
    op_t                       s1_op_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    logic [PERIOD_W-1:0]       s1_period_reg;
    logic signed [COUNT_W-1:0] s1_count_reg;
    logic [PULSES_W-1:0]       s1_pulses_reg;
    logic [NEED_W-1:0]         s1_need_reg;
    logic [NEED_W-1:0]         need_next;

    logic out_valid_reg;
    logic s1_fire;
    logic in_fire;

    assign s1_fire     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // pulses * pulse_ticks * 2, time to fit all bursts in one period
    assign need_next = {24'(in_ch.pulse_count) * 24'(pulse_ticks_reg), 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg     <= in_ch.op;
            s1_idx_reg    <= in_ch.led_index;
            s1_period_reg <= in_ch.period_ticks;
            s1_count_reg  <= in_ch.flash_count;
            s1_pulses_reg <= in_ch.pulse_count;
            s1_need_reg   <= need_next;
        end
    end

    // tick counter; tick_plus_reg always holds tick_now + 1
    logic [TICK_W-1:0] tick_now_reg;
    logic [TICK_W-1:0] tick_plus_reg;
    logic              is_tick;

    assign is_tick = (s1_op_reg == OP_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now_reg  <= '0;
            tick_plus_reg <= TICK_W'(1);
        end
        else if (s1_fire && is_tick)
        begin
            tick_now_reg  <= tick_plus_reg;
            tick_plus_reg <= tick_plus_reg + TICK_W'(1);
        end
    end

    // shared flash / pulse start check
    logic [NEED_W-1:0]  p_wide;
    logic [STORE_W-1:0] start_period;
    logic               flash_ok;
    logic [REP_W-1:0]   rep_init;

    assign p_wide       = (NEED_W'(s1_period_reg) > s1_need_reg) ? NEED_W'(s1_period_reg)
                                                                 : s1_need_reg;
    assign start_period = (s1_op_reg == OP_PULSE) ? {p_wide, 1'b0}
                                                  : STORE_W'(s1_period_reg);
    assign flash_ok     = start_period >= STORE_W'(min_period_reg);
    // count - 1; a zero count gives -1 and so flashes forever
    assign rep_init     = {s1_count_reg[COUNT_W-1], s1_count_reg} - REP_W'(1);

    // per-LED state
    logic                lit_reg        [LED_COUNT];
    logic                lit_next       [LED_COUNT];
    logic                active_reg     [LED_COUNT];
    logic                active_next    [LED_COUNT];
    logic                phase_reg      [LED_COUNT];
    logic                phase_next     [LED_COUNT];
    logic [STORE_W-1:0]  period_reg     [LED_COUNT];
    logic [STORE_W-1:0]  period_next    [LED_COUNT];
    logic [REP_W-1:0]    rep_reg        [LED_COUNT];
    logic [REP_W-1:0]    rep_next       [LED_COUNT];
    logic [PULSES_W-1:0] bsize_reg      [LED_COUNT];
    logic [PULSES_W-1:0] bsize_next     [LED_COUNT];
    logic [BURST_W-1:0]  bleft_reg      [LED_COUNT];
    logic [BURST_W-1:0]  bleft_next     [LED_COUNT];
    logic [TICK_W-1:0]   pstamp_reg     [LED_COUNT];
    logic [TICK_W-1:0]   pstamp_next    [LED_COUNT];
    logic [TICK_W-1:0]   ustamp_reg     [LED_COUNT];
    logic [TICK_W-1:0]   ustamp_next    [LED_COUNT];
    logic [LED_COUNT-1:0] ok_vec;

    genvar gi;
    generate
        for (gi = 0; gi < LED_COUNT; gi++)
        begin : g_led
            logic              sel;
            logic              ok_led;
            logic [TICK_W-1:0] el_pulse;
            logic [TICK_W-1:0] el_period;

            assign sel       = !is_tick && (s1_idx_reg == IDX_W'(gi));
            assign el_pulse  = tick_plus_reg - ustamp_reg[gi];
            assign el_period = tick_plus_reg - pstamp_reg[gi];
            assign ok_vec[gi] = ok_led;

            always_comb
            begin
                lit_next[gi]    = lit_reg[gi];
                active_next[gi] = active_reg[gi];
                phase_next[gi]  = phase_reg[gi];
                period_next[gi] = period_reg[gi];
                rep_next[gi]    = rep_reg[gi];
                bsize_next[gi]  = bsize_reg[gi];
                bleft_next[gi]  = bleft_reg[gi];
                pstamp_next[gi] = pstamp_reg[gi];
                ustamp_next[gi] = ustamp_reg[gi];
                ok_led          = 1'b0;

                if (s1_fire && is_tick)
                begin
                    if (active_reg[gi] && lit_reg[gi])
                    begin
                        if (!bleft_reg[gi][BURST_W-1] && bleft_reg[gi] != '0)
                        begin
                            // inside a burst of short blinks
                            if ({el_pulse, 1'b0} > {17'd0, pulse_ticks_reg})
                            begin
                                phase_next[gi]  = !phase_reg[gi];
                                if (phase_reg[gi])
                                    bleft_next[gi] = bleft_reg[gi] - BURST_W'(1);
                                ustamp_next[gi] = tick_plus_reg;
                            end
                        end
                        else if (el_period > TICK_W'(period_reg[gi]))
                        begin
                            if (rep_reg[gi] != '0)
                            begin
                                phase_next[gi] = !phase_reg[gi];
                                if (bsize_reg[gi] != '0)
                                begin
                                    bleft_next[gi]  = {1'b0, bsize_reg[gi]};
                                    ustamp_next[gi] = tick_plus_reg;
                                    if (!rep_reg[gi][REP_W-1])
                                        rep_next[gi] = rep_reg[gi] - REP_W'(1);
                                end
                                else if (!rep_reg[gi][REP_W-1] && !phase_reg[gi])
                                begin
                                    rep_next[gi] = rep_reg[gi] - REP_W'(1);
                                end
                            end
                            else
                            begin
                                lit_next[gi]    = 1'b0;
                                active_next[gi] = 1'b0;
                                phase_next[gi]  = 1'b0;
                                rep_next[gi]    = '0;
                                bsize_next[gi]  = '0;
                                bleft_next[gi]  = BURST_IDLE;
                            end
                            pstamp_next[gi] = tick_plus_reg;
                        end
                    end
                end
                else if (s1_fire && sel)
                begin
                    case (s1_op_reg)
                        OP_ON:
                        begin
                            if (!lit_reg[gi])
                            begin
                                lit_next[gi] = 1'b1;
                                if (active_reg[gi])
                                    phase_next[gi] = 1'b1;
                                ok_led = 1'b1;
                            end
                        end
                        OP_OFF, OP_TOGGLE:
                        begin
                            if (lit_reg[gi])
                            begin
                                lit_next[gi]    = 1'b0;
                                active_next[gi] = 1'b0;
                                phase_next[gi]  = 1'b0;
                                rep_next[gi]    = '0;
                                bsize_next[gi]  = '0;
                                bleft_next[gi]  = BURST_IDLE;
                                ok_led          = 1'b1;
                            end
                            else if (s1_op_reg == OP_TOGGLE)
                            begin
                                lit_next[gi] = 1'b1;
                                if (active_reg[gi])
                                    phase_next[gi] = 1'b1;
                                ok_led = 1'b1;
                            end
                        end
                        OP_FLASH, OP_PULSE:
                        begin
                            // pulse turns the LED off first, even if the start fails
                            if (s1_op_reg == OP_PULSE && lit_reg[gi])
                            begin
                                lit_next[gi]    = 1'b0;
                                active_next[gi] = 1'b0;
                                phase_next[gi]  = 1'b0;
                                rep_next[gi]    = '0;
                                bsize_next[gi]  = '0;
                                bleft_next[gi]  = BURST_IDLE;
                            end
                            if (flash_ok)
                            begin
                                lit_next[gi]    = 1'b1;
                                active_next[gi] = 1'b1;
                                phase_next[gi]  = 1'b1;
                                period_next[gi] = start_period;
                                rep_next[gi]    = rep_init;
                                pstamp_next[gi] = tick_now_reg;
                                ok_led          = 1'b1;
                                if (s1_op_reg == OP_PULSE)
                                begin
                                    bsize_next[gi]  = s1_pulses_reg;
                                    bleft_next[gi]  = {1'b0, s1_pulses_reg};
                                    ustamp_next[gi] = tick_now_reg;
                                end
                                else
                                begin
                                    bsize_next[gi] = '0;
                                    bleft_next[gi] = BURST_IDLE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    lit_reg[gi]    <= 1'b0;
                    active_reg[gi] <= 1'b0;
                    phase_reg[gi]  <= 1'b0;
                    period_reg[gi] <= PERIOD_RST;
                    rep_reg[gi]    <= '0;
                    bsize_reg[gi]  <= '0;
                    bleft_reg[gi]  <= BURST_IDLE;
                    pstamp_reg[gi] <= '0;
                    ustamp_reg[gi] <= '0;
                end
                else
                begin
                    lit_reg[gi]    <= lit_next[gi];
                    active_reg[gi] <= active_next[gi];
                    phase_reg[gi]  <= phase_next[gi];
                    period_reg[gi] <= period_next[gi];
                    rep_reg[gi]    <= rep_next[gi];
                    bsize_reg[gi]  <= bsize_next[gi];
                    bleft_reg[gi]  <= bleft_next[gi];
                    pstamp_reg[gi] <= pstamp_next[gi];
                    ustamp_reg[gi] <= ustamp_next[gi];
                end
            end
        end
    endgenerate

    // result for the visible LEDs, taken from the updated state
    logic [OUT_W-1:0] pins_next;
    logic [OUT_W-1:0] lits_next;

    generate
        for (gi = 0; gi < OUT_W; gi++)
        begin : g_out
            if (gi < LED_COUNT)
            begin : g_used
                logic shown;
                assign shown         = active_next[gi] ? phase_next[gi] : lit_next[gi];
                assign pins_next[gi] = (shown == pol_reg[gi]);
                assign lits_next[gi] = lit_next[gi];
            end
            else
            begin : g_unused
                assign pins_next[gi] = 1'b0;
                assign lits_next[gi] = 1'b0;
            end
        end
    endgenerate

    // result register
    logic [OUT_W-1:0] pins_reg;
    logic [OUT_W-1:0] lits_reg;
    logic             ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            pins_reg <= pins_next;
            lits_reg <= lits_next;
            ok_reg   <= is_tick || (|ok_vec);
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pin_levels = pins_reg;
    assign out_ch.lit_flags  = lits_reg;
    assign out_ch.ok         = ok_reg;

    // checks
    a_tick_ok : assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && is_tick |=> out_ch.valid && out_ch.ok)
        else $error("tick result without ok");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !s1_fire)
        else $error("result register overwritten while stalled");

    generate
        for (gi = 0; gi < LED_COUNT; gi++)
        begin : g_chk
            a_active_lit : assert property (@(posedge clk) disable iff (!rst_n)
                active_reg[gi] |-> lit_reg[gi])
                else $error("flashing LED not lit");

            a_burst_active : assert property (@(posedge clk) disable iff (!rst_n)
                (!bleft_reg[gi][BURST_W-1] && bleft_reg[gi] != '0) |-> active_reg[gi])
                else $error("burst pending on idle LED");
        end
    endgenerate

endmodule

FILE: bench/lfps_checker.sv
module lfps_checker
    import lfps_pkg::*;
#(
    parameter int LEDS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    lfps_in_if               in_mon,
    lfps_out_if              out_mon,
    output int unsigned      pending,
    output int unsigned      failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUT_W-1:0] pins;
        logic [OUT_W-1:0] lits;
        logic             ok;
    } led_status_t;

    led_status_t status_due [$];
    led_status_t due;
    led_status_t fresh;
    int unsigned n_results;

    logic [OUT_W-1:0] polarity;
    logic [CFG_W-1:0] min_period;
    logic [CFG_W-1:0] blink_len;

    logic [TICK_W-1:0]         now_ms;
    logic                      lit      [LEDS];
    logic                      flashing [LEDS];
    logic                      phase_on [LEDS];
    logic [STORE_W-1:0]        period   [LEDS];
    logic signed [REP_W-1:0]   reps     [LEDS];
    logic [PULSES_W-1:0]       bsize    [LEDS];
    logic signed [BURST_W-1:0] bleft    [LEDS];
    logic [TICK_W-1:0]         pstamp   [LEDS];
    logic [TICK_W-1:0]         bstamp   [LEDS];

    task automatic report(input string what);
        failures = failures + 1;
        $display("%0t ns: result %0d: %s", $time, n_results, what);
    endtask

    task automatic clear_model();
        polarity   = POLARITY_RST;
        min_period = MIN_PERIOD_RST;
        blink_len  = PULSE_RST;
        now_ms     = '0;
        for (int i = 0; i < LEDS; i++)
        begin
            lit[i]      = 1'b0;
            flashing[i] = 1'b0;
            phase_on[i] = 1'b0;
            period[i]   = PERIOD_RST;
            reps[i]     = '0;
            bsize[i]    = '0;
            bleft[i]    = BURST_IDLE;
            pstamp[i]   = '0;
            bstamp[i]   = '0;
        end
    endtask

    // going dark always cancels flashing and any burst
    task automatic set_lit(input int i, input logic on);
        if (!on)
        begin
            phase_on[i] = 1'b0;
            flashing[i] = 1'b0;
            reps[i]     = '0;
            bsize[i]    = '0;
            bleft[i]    = BURST_IDLE;
        end
        lit[i] = on;
        if (flashing[i])
            phase_on[i] = on;
    endtask

    task automatic start_flash(input int i, input logic [TICK_W-1:0] per,
                               input logic signed [COUNT_W-1:0] cnt, output logic taken);
        taken = (per >= min_period);
        if (taken)
        begin
            flashing[i] = 1'b1;
            period[i]   = per[STORE_W-1:0];
            reps[i]     = {cnt[COUNT_W-1], cnt} - 1'b1;
            bsize[i]    = '0;
            bleft[i]    = BURST_IDLE;
            pstamp[i]   = now_ms;
            set_lit(i, 1'b1);
        end
    endtask

    task automatic advance_led(input int i);
        logic [TICK_W:0] twice;
        logic            counted;
        if (flashing[i] && lit[i])
        begin
            if (bleft[i] > 0)
            begin
                // short blink: toggle once more than half a pulse has gone by
                twice = {now_ms - bstamp[i], 1'b0};
                if (twice > blink_len)
                begin
                    phase_on[i] = !phase_on[i];
                    if (!phase_on[i])
                        bleft[i] = bleft[i] - 1'b1;
                    bstamp[i] = now_ms;
                end
            end
            else if (now_ms - pstamp[i] > period[i])
            begin
                if (reps[i] != 0)
                begin
                    counted     = (reps[i] > 0);
                    phase_on[i] = !phase_on[i];
                    if (bsize[i] != 0)
                    begin
                        bleft[i]  = {1'b0, bsize[i]};
                        bstamp[i] = now_ms;
                        if (counted)
                            reps[i] = reps[i] - 1'b1;
                    end
                    else if (counted && phase_on[i])
                        reps[i] = reps[i] - 1'b1;
                end
                else
                    set_lit(i, 1'b0);
                pstamp[i] = now_ms;
            end
        end
    endtask

    task automatic step_leds(input op_t op, input logic [IDX_W-1:0] idx,
                             input logic [PERIOD_W-1:0] per,
                             input logic signed [COUNT_W-1:0] cnt,
                             input logic [PULSES_W-1:0] pul, output led_status_t res);
        logic              taken;
        logic [TICK_W-1:0] need;
        logic [TICK_W-1:0] span;
        logic              shown;
        int                l;
        taken = 1'b0;
        l = int'(idx);
        if (op == OP_TICK)
        begin
            now_ms = now_ms + 1'b1;
            for (int i = 0; i < LEDS; i++)
                advance_led(i);
            taken = 1'b1;
        end
        else if (l < LEDS)
        begin
            case (op)
                OP_ON:
                begin
                    taken = !lit[l];
                    if (taken)
                        set_lit(l, 1'b1);
                end
                OP_OFF:
                begin
                    taken = lit[l];
                    if (taken)
                        set_lit(l, 1'b0);
                end
                OP_TOGGLE:
                begin
                    set_lit(l, !lit[l]);
                    taken = 1'b1;
                end
                OP_FLASH:
                    start_flash(l, TICK_W'(per), cnt, taken);
                OP_PULSE:
                begin
                    // widen to fit the bursts, then double
                    need = pul * blink_len * 2;
                    span = (per > need) ? TICK_W'(per) : need;
                    if (lit[l])
                        set_lit(l, 1'b0);
                    start_flash(l, {span[TICK_W-2:0], 1'b0}, cnt, taken);
                    if (taken)
                    begin
                        bsize[l]  = pul;
                        bleft[l]  = {1'b0, pul};
                        bstamp[l] = now_ms;
                    end
                end
                default: ;
            endcase
        end
        res.pins = '0;
        res.lits = '0;
        res.ok   = taken;
        for (int i = 0; i < LEDS && i < OUT_W; i++)
        begin
            shown = flashing[i] ? phase_on[i] : lit[i];
            res.pins[i] = (shown == polarity[i]);
            res.lits[i] = lit[i];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            status_due.delete();
            n_results = 0;
            failures  = 0;
            pending  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POLARITY:   polarity   = cfg_data[OUT_W-1:0];
                    CFG_MIN_PERIOD: min_period = cfg_data;
                    CFG_PULSE:      blink_len  = cfg_data;
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (status_due.size() == 0)
                    report($sformatf("unexpected item pins=%h lits=%h ok=%b",
                                     out_mon.pin_levels, out_mon.lit_flags, out_mon.ok));
                else
                begin
                    due = status_due.pop_front();
                    if (out_mon.pin_levels !== due.pins)
                        report($sformatf("pin_levels %h, want %h", out_mon.pin_levels, due.pins));
                    if (out_mon.lit_flags !== due.lits)
                        report($sformatf("lit_flags %h, want %h", out_mon.lit_flags, due.lits));
                    if (out_mon.ok !== due.ok)
                        report($sformatf("ok %b, want %b", out_mon.ok, due.ok));
                end
                n_results = n_results + 1;
            end
            if (in_mon.valid && in_mon.ready)
            begin
                step_leds(in_mon.op, in_mon.led_index, in_mon.period_ticks, in_mon.flash_count,
                          in_mon.pulse_count, fresh);
                status_due.push_back(fresh);
            end
            pending <= status_due.size();
        end
    end

endmodule

FILE: bench/led_flash_pulse_sequencer_top_tb.sv
module led_flash_pulse_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfps_pkg::*;

    localparam op_t OP_SPARE_LO = 3'd6;
    localparam op_t OP_SPARE_HI = 3'd7;
    localparam int  LONG_HOLD   = 64;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int unsigned      pending;
    int unsigned      failures;

    logic             idle_on    = 1'b1;
    int unsigned      hold_reqs  = 0;
    int unsigned      holds_done = 0;
    logic [CFG_W-1:0] cur_min    = MIN_PERIOD_RST;
    int unsigned      n_items    = 0;
    int unsigned      n_ticks    = 0;
    int unsigned      n_settings = 0;

    lfps_in_if  in_ch ();
    lfps_out_if out_ch ();

    led_flash_pulse_sequencer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    lfps_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .pending   (pending),
        .failures  (failures)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin : sink_side
        int n;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_reqs != holds_done)
            begin
                holds_done++;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 8);
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
                             input logic [PERIOD_W-1:0] per,
                             input logic signed [COUNT_W-1:0] cnt,
                             input logic [PULSES_W-1:0] pul, input logic may_gap);
        int gap;
        if (idle_on && may_gap && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.led_index    <= idx;
        in_ch.period_ticks <= per;
        in_ch.flash_count  <= cnt;
        in_ch.pulse_count  <= pul;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        n_items++;
        if (op == OP_TICK)
            n_ticks++;
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_config(input logic [OUT_W-1:0] pol, input logic [CFG_W-1:0] minp,
                              input logic [CFG_W-1:0] blink);
        cfg_idx_t         which [3];
        logic [CFG_W-1:0] val   [3];
        wait_drain();
        which = '{CFG_POLARITY, CFG_MIN_PERIOD, CFG_PULSE};
        val   = '{CFG_W'(pol), minp, blink};
        for (int k = 0; k < 3; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= which[k];
            cfg_data  <= val[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_min = minp;
        n_settings++;
    endtask

    // mostly ticks; flash and pulse mostly well-formed so LEDs run through their cycles
    task automatic send_random(input logic may_gap);
        op_t                       op;
        logic [IDX_W-1:0]          idx;
        logic [PERIOD_W-1:0]       per;
        logic signed [COUNT_W-1:0] cnt;
        logic [PULSES_W-1:0]       pul;
        int unsigned               pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            idx = IDX_W'($urandom_range(4, 15));
        else
            idx = IDX_W'($urandom_range(0, 3));
        per = PERIOD_W'($urandom);
        cnt = COUNT_W'($urandom);
        pul = PULSES_W'($urandom);
        if (pick < 65)
            op = OP_TICK;
        else if (pick < 70)
            op = OP_ON;
        else if (pick < 75)
            op = OP_OFF;
        else if (pick < 80)
            op = OP_TOGGLE;
        else if (pick < 90)
            op = OP_FLASH;
        else if (pick < 98)
            op = OP_PULSE;
        else if (pick < 99)
            op = OP_SPARE_LO;
        else
            op = OP_SPARE_HI;
        if ((op == OP_FLASH || op == OP_PULSE) && $urandom_range(0, 7) != 0)
        begin
            if (op == OP_PULSE)
            begin
                per = PERIOD_W'($urandom_range(0, 16));
                pul = PULSES_W'($urandom_range(0, 3));
            end
            else if ($urandom_range(0, 9) == 0)
                per = PERIOD_W'(cur_min) - 1'b1;
            else
                per = PERIOD_W'(cur_min) + PERIOD_W'($urandom_range(0, 8));
            case ($urandom_range(0, 9))
                0:       cnt = COUNT_W'(-1);
                1:       cnt = '0;
                default: cnt = COUNT_W'($urandom_range(1, 5));
            endcase
        end
        send_item(op, idx, per, cnt, pul, may_gap);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_POLARITY;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.op           <= OP_TICK;
        in_ch.led_index    <= '0;
        in_ch.period_ticks <= '0;
        in_ch.flash_count  <= '0;
        in_ch.pulse_count  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        set_config(POLARITY_RST, MIN_PERIOD_RST, PULSE_RST);
        send_item(OP_ON,       4'd0,  24'd0,      17'sd0,      8'd0,   1'b1);
        send_item(OP_ON,       4'd0,  24'd0,      17'sd0,      8'd0,   1'b1);
        send_item(OP_OFF,      4'd3,  24'd0,      17'sd0,      8'd0,   1'b1);
        send_item(OP_TOGGLE,   4'd1,  24'd0,      17'sd0,      8'd0,   1'b1);
        send_item(OP_TOGGLE,   4'd1,  24'd0,      17'sd0,      8'd0,   1'b1);
        send_item(OP_FLASH,    4'd2,  24'd99,     17'sd1,      8'd0,   1'b1);
        send_item(OP_FLASH,    4'd2,  24'd100,    17'sd1,      8'd0,   1'b1);
        send_item(OP_FLASH,    4'd3,  24'hFFFFFF, -17'sd1,     8'd0,   1'b1);
        send_item(OP_FLASH,    4'd1,  24'd100,    17'sd0,      8'd0,   1'b1);
        // too short even when doubled: LED ends up dark
        send_item(OP_PULSE,    4'd3,  24'd0,      17'sd1,      8'd0,   1'b1);
        send_item(OP_PULSE,    4'd2,  24'd0,      17'sh0FFFF,  8'hFF,  1'b1);
        send_item(OP_ON,       4'd4,  24'd0,      17'sd0,      8'd0,   1'b1);
        send_item(OP_TOGGLE,   4'd15, 24'd0,      17'sd0,      8'd0,   1'b1);
        send_item(OP_SPARE_LO, 4'd0,  24'd0,      17'sd0,      8'd0,   1'b1);
        send_item(OP_SPARE_HI, 4'd1,  24'hFFFFFF, -17'sd1,     8'hFF,  1'b1);
        send_item(OP_TICK,     4'd15, 24'hFFFFFF, -17'sd1,     8'hFF,  1'b1);
        send_item(OP_TOGGLE,   4'd2,  24'd0,      17'sd0,      8'd0,   1'b1);
        send_item(OP_FLASH,    4'd0,  24'd200,    17'sh10000,  8'd0,   1'b1);
        send_item(OP_OFF,      4'd0,  24'd0,      17'sd0,      8'd0,   1'b1);

        set_config(OUT_W'($urandom), 16'd1, 16'd2);
        send_item(OP_FLASH,    4'd0,  24'd1,      17'sd2,      8'd0,   1'b1);
        send_item(OP_PULSE,    4'd1,  24'd0,      17'sd2,      8'd2,   1'b1);
        send_item(OP_PULSE,    4'd2,  24'hFFFFFF, 17'sd1,      8'hFF,  1'b1);
        repeat (300) send_random(1'b1);

        set_config(4'h0, 16'hFFFF, 16'hFFFF);
        repeat (100) send_random(1'b1);

        set_config(OUT_W'($urandom), CFG_W'($urandom_range(1, 8)),
                   CFG_W'($urandom_range(2, 6)));
        for (int k = 0; k < 250; k++)
        begin
            // long output hold with the input kept busy, later a full drain
            if (k == 40)
                hold_reqs++;
            if (k == 150)
                wait_drain();
            send_random(!(k >= 40 && k < 80));
        end

        set_config(4'hF, 16'd2, 16'd3);
        idle_on = 1'b0;
        repeat (250) send_random(1'b1);

        wait_drain();
        repeat (8) @(posedge clk);
        $display("Ran %0d items (%0d ticks) under %0d register settings, incl. a long output stall",
                 n_items, n_ticks, n_settings);
        $display("%0d mismatches found", failures);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
